[hdl/hrtq_pkg.sv]
`default_nettype none
package hrtq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH        = 16;
  localparam int DEBUG_REPORT_BYTES = 32;
  localparam int SLOT_WORDS         = (DEBUG_REPORT_BYTES + 7) / 8;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int WI_W   = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
  localparam int PAY_DEPTH = QUEUE_DEPTH * SLOT_WORDS;
  localparam int ADDR_W = $clog2(PAY_DEPTH);

  // Fixed ids and lengths
  localparam logic [2:0] MACRO_ID     = 3'd2;
  localparam logic [6:0] MACRO_LEN    = 7'd8;
  localparam logic [2:0] MOTION_ID    = 3'd3;
  localparam logic [63:0] MOTION_MASK = 64'hFFFF_FFFF_0000_00FF;

  typedef enum logic [3:0] {
    OP_LINK     = 4'd0,
    OP_SYNC     = 4'd1,
    OP_START    = 4'd2,
    OP_RESET    = 4'd3,
    OP_ENQUEUE  = 4'd4,
    OP_MACRO    = 4'd5,
    OP_PENDING  = 4'd6,
    OP_DISCARD  = 4'd7,
    OP_CLEAR    = 4'd8,
    OP_TRANSMIT = 4'd9,
    OP_COMPLETE = 4'd10,
    OP_FAIL     = 4'd11
  } opcode_t;

  typedef enum logic [0:0] {
    CFG_DEBUG_ID = 1'b0,
    CFG_RESERVED = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP,
    ST_TXRD
  } ctrl_state_t;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [7:0]  rpt_id;
    logic [7:0]  rpt_len;
    logic [2:0]  word_index;
    logic [63:0] data_word;
    logic        last_word;
    logic        link_connected;
    logic        link_suspended;
    logic        report_is_input;
    logic        endpoint_ready;
    logic        endpoint_accepted;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        link_ready;
    logic        pending_found;
    logic        tx_valid;
    logic [2:0]  tx_report_id;
    logic [6:0]  tx_length;
    logic [2:0]  tx_word_index;
    logic [63:0] tx_word;
    logic        last_result;
    logic [4:0]  queue_count;
    logic        busy_flag;
    logic        retry_flag;
  } out_item_t;

  // Fixed byte length per report id
  function automatic logic [6:0] fixed_length(input logic [2:0] id);
    logic [6:0] len;
    unique case (id)
      3'd1:    len = 7'(DEBUG_REPORT_BYTES);
      3'd2:    len = 7'd8;
      3'd3:    len = 7'd4;
      3'd4:    len = 7'd1;
      default: len = 7'd0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

[hdl/hid_report_tx_queue.sv]
// HID report transmit queue.
// Input channel in_valid/in_ready/in_data carries one command beat (link change,
// owner control, enqueue word, macro, pending query, motion discard, clear,
// transmit, complete, fail). Output channel out_valid/out_ready/out_data returns
// the results: one status beat per command, or one beat per payload word for a
// transmit the endpoint accepted (up to four words, last_result on the final).
// cfg_we/cfg_index/cfg_data write the debug report id and reserved slot count.
// One command is handled at a time: accept, execute, then the result beats.
// A transmit's payload words are paced by the payload memory's one registered
// read port, one word per cycle while the output register is not stalled.
// Results pass through an output register, so a command is accepted while the
// previous result beat still waits there.
// Reset clears pointers, counts, link and owner state; payload and slot
// memories need no clearing. When out_ready is low the output register holds
// its beat; the controller stalls on its result, in_ready low, until it drains.
`default_nettype none
module hid_report_tx_queue
  import hrtq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [3:0] cfg_data
);

  logic      res_valid, res_ready;
  out_item_t res_data;
  logic      out_valid_r;
  out_item_t out_data_r;

  hrtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Load output register when empty or draining
  assign res_ready = ~out_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[hdl/hrtq_ram.sv]
`default_nettype none
module hrtq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/hrtq_ctrl.sv]
`default_nettype none
module hrtq_ctrl
  import hrtq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           res_valid,
  input  wire logic      res_ready,
  output out_item_t      res_data,
  input  wire logic      cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [3:0] cfg_data
);

  ctrl_state_t state_r, state_nxt;
  in_item_t    item_r;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic flight_r, flight_nxt;
  logic [2:0] fid_r, fid_nxt;
  logic mounted_r, mounted_nxt, sleeping_r, sleeping_nxt;
  logic started_r, started_nxt, active_r, active_nxt;
  logic stale_r, stale_nxt, retry_r, retry_nxt, open_r, open_nxt;
  logic acc_r, acc_nxt, found_r, found_nxt;
  logic [2:0] dbg_id_r;
  logic [3:0] rsv_r;

  // Slot metadata
  logic [2:0] sid_r  [QUEUE_DEPTH];
  logic [6:0] slen_r [QUEUE_DEPTH];
  logic [SLOT_WORDS-1:0] wmask_r [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] zap_r;

  // Transfer in progress
  logic [PTR_W-1:0] tslot_r, tslot_nxt;
  logic [2:0] tid_r, tid_nxt;
  logic [6:0] tlen_r, tlen_nxt;
  logic [3:0] tn_r, tn_nxt, ti_r, ti_nxt;

  logic adm_we, wr_we;
  logic [PTR_W-1:0] adm_slot, wr_slot;
  logic [2:0] adm_id;
  logic [6:0] adm_len;
  logic [WI_W-1:0] wr_widx;
  logic [QUEUE_DEPTH-1:0] zap_set, in_q;

  logic ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [63:0] ram_wdata, ram_rdata;

  logic link_ok, ok, hit;
  logic [PTR_W-1:0] tail;
  logic [PTR_W:0] tail_sum, head_inc;
  logic [CNT_W-1:0] limit;
  logic [2:0] in_id3;
  logic [6:0] hlen;
  logic [3:0] n_words;
  logic [63:0] tx_w;

  hrtq_ram #(.DEPTH(PAY_DEPTH), .WIDTH(64)) u_pay (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .re     (ram_re),
    .raddr  (ram_raddr),
    .rdata_r(ram_rdata)
  );

  assign link_ok = active_r & mounted_r & ~sleeping_r & ~retry_r & ~stale_r;
  assign in_ready = (state_r == ST_IDLE);

  // Tail slot and head advance with wrap
  always_comb begin
    tail_sum = (PTR_W+1)'(head_r) + (PTR_W+1)'(count_r);
    if (tail_sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (PTR_W+1)'(QUEUE_DEPTH);
    end
    tail = tail_sum[PTR_W-1:0];
    head_inc = (PTR_W+1)'(head_r) + (PTR_W+1)'(1);
    if (head_inc >= (PTR_W+1)'(QUEUE_DEPTH)) begin
      head_inc = '0;
    end
  end

  // Mark slots holding committed entries
  always_comb begin
    for (int s = 0; s < QUEUE_DEPTH; s++) begin
      if (s >= int'(head_r)) begin
        in_q[s] = (s - int'(head_r)) < int'(count_r);
      end else begin
        in_q[s] = (s + QUEUE_DEPTH - int'(head_r)) < int'(count_r);
      end
    end
  end

  // Admission terms
  assign in_id3 = item_r.rpt_id[2:0];
  assign limit  = (int'(rsv_r) >= QUEUE_DEPTH) ? '0 : CNT_W'(QUEUE_DEPTH - int'(rsv_r));
  assign ok = (item_r.rpt_id >= 8'd1) && (item_r.rpt_id <= 8'd4) &&
              (item_r.rpt_len == {1'b0, fixed_length(in_id3)}) && link_ok &&
              (int'(count_r) < QUEUE_DEPTH) &&
              !((item_r.rpt_id == {5'd0, dbg_id_r}) && (count_r >= limit));
  assign hlen = slen_r[head_r];
  assign n_words = (({1'b0, hlen} + 8'd7) >> 3) > 8'(SLOT_WORDS) ?
                   4'(SLOT_WORDS) : 4'(({1'b0, hlen} + 8'd7) >> 3);

  // Pending search over the in-flight report and queued slots
  always_comb begin
    hit = flight_r && ({5'd0, fid_r} == item_r.rpt_id);
    for (int s = 0; s < QUEUE_DEPTH; s++) begin
      if (in_q[s] && ({5'd0, sid_r[s]} == item_r.rpt_id)) begin
        hit = 1'b1;
      end
    end
  end

  // Mask the word being sent
  always_comb begin
    tx_w = ram_rdata;
    if (!wmask_r[tslot_r][ti_r[WI_W-1:0]]) begin
      tx_w = '0;
    end
    if (ti_r == 4'd0 && zap_r[tslot_r]) begin
      tx_w = tx_w & MOTION_MASK;
    end
    for (int b = 0; b < 8; b++) begin
      if (int'(ti_r) * 8 + b >= int'(tlen_r)) begin
        tx_w[b*8 +: 8] = 8'd0;
      end
    end
  end

  // Next state and step execution
  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r;  count_nxt = count_r;
    flight_nxt = flight_r;  fid_nxt = fid_r;
    mounted_nxt = mounted_r;  sleeping_nxt = sleeping_r;
    started_nxt = started_r;  active_nxt = active_r;
    stale_nxt = stale_r;  retry_nxt = retry_r;  open_nxt = open_r;
    acc_nxt = acc_r;  found_nxt = found_r;
    tslot_nxt = tslot_r;  tid_nxt = tid_r;  tlen_nxt = tlen_r;
    tn_nxt = tn_r;  ti_nxt = ti_r;
    adm_we = 1'b0;  adm_slot = tail;  adm_id = in_id3;  adm_len = item_r.rpt_len[6:0];
    wr_we = 1'b0;  wr_slot = tail;  wr_widx = item_r.word_index[WI_W-1:0];
    zap_set = '0;
    ram_we = 1'b0;
    ram_waddr = ADDR_W'(int'(tail) * SLOT_WORDS + int'(item_r.word_index));
    ram_wdata = item_r.data_word;
    ram_re = 1'b0;
    ram_raddr = ADDR_W'(int'(tslot_r) * SLOT_WORDS + int'(ti_r));
    res_valid = 1'b0;
    res_data = '0;
    res_data.link_ready  = link_ok;
    res_data.queue_count = 5'(count_r);
    res_data.busy_flag   = flight_r;
    res_data.retry_flag  = retry_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        acc_nxt = 1'b0;
        found_nxt = 1'b0;
        state_nxt = ST_RESP;
        unique case (opcode_t'(item_r.opcode))
          OP_LINK: begin
            mounted_nxt = item_r.link_connected;
            sleeping_nxt = item_r.link_suspended;
            stale_nxt = 1'b1;
            head_nxt = '0;  count_nxt = '0;  open_nxt = 1'b0;
            flight_nxt = 1'b0;
          end
          OP_SYNC: begin
            stale_nxt = 1'b0;
            active_nxt = mounted_r & ~sleeping_r & started_r;
            retry_nxt = 1'b0;
          end
          OP_START: begin
            started_nxt = 1'b1;
            stale_nxt = 1'b0;
            active_nxt = mounted_r & ~sleeping_r;
            retry_nxt = 1'b0;
          end
          OP_RESET: begin
            started_nxt = 1'b0;
            active_nxt = 1'b0;
            stale_nxt = 1'b1;
          end
          OP_ENQUEUE: begin
            if (open_r || ok) begin
              adm_we = ~open_r;
              acc_nxt = 1'b1;
              open_nxt = 1'b1;
              if (int'(item_r.word_index) < SLOT_WORDS) begin
                wr_we = 1'b1;
                ram_we = 1'b1;
              end
              if (item_r.last_word) begin
                count_nxt = count_r + CNT_W'(1);
                open_nxt = 1'b0;
              end
            end
          end
          OP_MACRO: begin
            if (link_ok && count_r == '0 && !flight_r && !open_r) begin
              adm_we = 1'b1;  adm_slot = head_r;  adm_id = MACRO_ID;  adm_len = MACRO_LEN;
              wr_we = 1'b1;  wr_slot = head_r;  wr_widx = '0;
              ram_we = 1'b1;
              ram_waddr = ADDR_W'(int'(head_r) * SLOT_WORDS);
              count_nxt = CNT_W'(1);
              acc_nxt = 1'b1;
            end
          end
          OP_PENDING: found_nxt = hit;
          OP_DISCARD: begin
            for (int s = 0; s < QUEUE_DEPTH; s++) begin
              zap_set[s] = in_q[s] && (sid_r[s] == MOTION_ID);
            end
          end
          OP_CLEAR: begin
            head_nxt = '0;  count_nxt = '0;  open_nxt = 1'b0;
          end
          OP_TRANSMIT: begin
            if (mounted_r && !sleeping_r && !flight_r && count_r != '0 &&
                item_r.endpoint_ready) begin
              head_nxt = head_inc[PTR_W-1:0];
              count_nxt = count_r - CNT_W'(1);
              flight_nxt = 1'b1;
              fid_nxt = sid_r[head_r];
              if (item_r.endpoint_accepted) begin
                tslot_nxt = head_r;  tid_nxt = sid_r[head_r];  tlen_nxt = hlen;
                tn_nxt = n_words;  ti_nxt = '0;
                if (n_words != 4'd0) begin
                  ram_re = 1'b1;
                  ram_raddr = ADDR_W'(int'(head_r) * SLOT_WORDS);
                  state_nxt = ST_TXRD;
                end
              end else begin
                flight_nxt = 1'b0;
                head_nxt = '0;  count_nxt = '0;  open_nxt = 1'b0;
                retry_nxt = 1'b1;
              end
            end
          end
          OP_COMPLETE: flight_nxt = 1'b0;
          OP_FAIL: begin
            if (item_r.report_is_input) begin
              flight_nxt = 1'b0;
              head_nxt = '0;  count_nxt = '0;  open_nxt = 1'b0;
              retry_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ST_RESP: begin
        res_valid = 1'b1;
        res_data.accepted = acc_r;
        res_data.pending_found = found_r;
        res_data.last_result = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TXRD: begin
        res_valid = 1'b1;
        res_data.tx_valid = 1'b1;
        res_data.tx_report_id = tid_r;
        res_data.tx_length = tlen_r;
        res_data.tx_word_index = ti_r[2:0];
        res_data.tx_word = tx_w;
        res_data.last_result = (ti_r + 4'd1 == tn_r);
        if (res_ready) begin
          ti_nxt = ti_r + 4'd1;
          if (ti_r + 4'd1 == tn_r) begin
            state_nxt = ST_IDLE;
          end else begin
            ram_re = 1'b1;
            ram_raddr = ADDR_W'(int'(tslot_r) * SLOT_WORDS + int'(ti_r) + 1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control and link state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;  count_r <= '0;  flight_r <= 1'b0;  fid_r <= '0;
      mounted_r <= 1'b0;  sleeping_r <= 1'b0;  started_r <= 1'b0;  active_r <= 1'b0;
      stale_r <= 1'b0;  retry_r <= 1'b0;  open_r <= 1'b0;
      acc_r <= 1'b0;  found_r <= 1'b0;
      dbg_id_r <= 3'd1;  rsv_r <= 4'd3;
    end else begin
      head_r <= head_nxt;  count_r <= count_nxt;  flight_r <= flight_nxt;  fid_r <= fid_nxt;
      mounted_r <= mounted_nxt;  sleeping_r <= sleeping_nxt;
      started_r <= started_nxt;  active_r <= active_nxt;
      stale_r <= stale_nxt;  retry_r <= retry_nxt;  open_r <= open_nxt;
      acc_r <= acc_nxt;  found_r <= found_nxt;
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_DEBUG_ID: dbg_id_r <= cfg_data[2:0];
          CFG_RESERVED: rsv_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Item and transfer payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    tslot_r <= tslot_nxt;  tid_r <= tid_nxt;  tlen_r <= tlen_nxt;
    tn_r <= tn_nxt;  ti_r <= ti_nxt;
  end

  // Slot metadata writes; an admission clears the word mask but for the word it stores
  always_ff @(posedge clk) begin
    if (adm_we) begin
      sid_r[adm_slot] <= adm_id;
      slen_r[adm_slot] <= adm_len;
      wmask_r[adm_slot] <= wr_we ? (SLOT_WORDS'(1) << wr_widx) : '0;
      zap_r[adm_slot] <= 1'b0;
    end else if (wr_we) begin
      wmask_r[wr_slot][wr_widx] <= 1'b1;
    end
    for (int s = 0; s < QUEUE_DEPTH; s++) begin
      if (zap_set[s]) begin
        zap_r[s] <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
